/* hw/rtl/lenv_pkg.sv */
// ---------------------------------------------------------------------------
// lenv_pkg
// Shared types and codes for the lower envelope of lines block.
// ---------------------------------------------------------------------------
`default_nettype none

package lenv_pkg;

   // Width of the configured right end
   localparam int CFG_WIDTH = 16;
   // Digit width of the shared multiplier
   localparam int DIGIT_W = 16;
   // Field widths fixed by the interface
   localparam int NUM_WIDTH = 32;
   localparam int DEN_WIDTH = 31;
   localparam int STATUS_WIDTH = 3;

   // Reset value of the right end
   localparam logic signed [CFG_WIDTH-1:0] RIGHT_END_RESET = 16'sd10002;

   // Request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DROP  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_ORDER = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP,
      S_DOM,
      S_POP_CHK,
      S_POP_MUL,
      S_POP_DEC,
      S_PUSH,
      S_Q_LOOP,
      S_Q_RD1,
      S_Q_SETUP,
      S_Q_STEP,
      S_Q_FIN,
      S_MUL,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/lower_envelope_of_lines.sv */
// ---------------------------------------------------------------------------
// lower_envelope_of_lines
// Stack of lines forming a lower envelope; insert with pruning, and
// binary-search query of the minimal line at a rational point.
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------
//  csr      | in  | csr_wr_en              | csr_wr_data: right_end
//  req      | in  | req_tvalid/req_tready  | tuser: req_type; tdata: see port
//  rsp      | out | rsp_tvalid/rsp_tready  | tuser: status;   tdata: see port
//
//  Every comparison runs on one shared 16-bit-digit multiplier, digit by
//  digit. Insert: a slope order check, then one compare for the dominance
//  test, then one compare per pop test: one per popped line and one that
//  stops the pops (none when the pops stop at one line). Query: one compare
//  per search step, at most ceil(log2(line count)) steps. One transaction
//  is in work at a time.
//  A result waits in the sequencer while the output register still holds an
//  unaccepted one; the next transaction is taken as soon as the sequencer is
//  idle. Reset is synchronous and empties the stack.
//
`default_nettype none

module lower_envelope_of_lines #(
   parameter int DEPTH = 1024,
   parameter int COEF_WIDTH = 48,
   localparam int SZW = $clog2(DEPTH + 1),
   localparam int REQ_BITS = 2 * COEF_WIDTH + lenv_pkg::NUM_WIDTH + lenv_pkg::DEN_WIDTH,
   localparam int REQ_DW = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = 2 * COEF_WIDTH + SZW,
   localparam int RSP_DW = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic [lenv_pkg::CFG_WIDTH-1:0] csr_wr_data,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [0:0] req_tuser,         // req_type
   // line_slope, line_intercept, point_numerator, point_denominator, zero pad
   input  wire logic [REQ_DW-1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [lenv_pkg::STATUS_WIDTH-1:0] rsp_tuser,   // status
   // best_slope, best_intercept, line_count, zero pad
   output logic [RSP_DW-1:0] rsp_tdata
);
   import lenv_pkg::*;

   localparam int AW = COEF_WIDTH + 1;
   localparam int BW = (COEF_WIDTH + 1 > NUM_WIDTH) ? COEF_WIDTH + 1 : NUM_WIDTH;
   localparam int NCH = (BW + DIGIT_W - 1) / DIGIT_W;
   localparam int BPW = NCH * DIGIT_W;
   localparam int PW = AW + DIGIT_W + 1;
   localparam int ACCW = AW + BPW + 2;
   localparam int ADW = $clog2(DEPTH);
   localparam int CNTW = $clog2(2 * NCH + 1);
   localparam int KW = $clog2(NCH);

   // stack storage
   logic [2*COEF_WIDTH-1:0] mem [DEPTH];
   logic [2*COEF_WIDTH-1:0] rd_ff;
   logic [ADW-1:0] rd_addr;
   logic mem_we;
   logic signed [COEF_WIDTH-1:0] rd_s, rd_b;

   // control and data registers
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [SZW-1:0] size_ff, size_in;
   logic signed [CFG_WIDTH-1:0] right_end_ff;
   logic signed [COEF_WIDTH-1:0] new_s_ff, new_s_in, new_b_ff, new_b_in;
   logic signed [NUM_WIDTH-1:0] num_ff, num_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic signed [COEF_WIDTH-1:0] top_s_ff, top_s_in, top_b_ff, top_b_in;
   logic signed [COEF_WIDTH-1:0] ent_s_ff, ent_s_in, ent_b_ff, ent_b_in;
   logic signed [COEF_WIDTH-1:0] res_s_ff, res_s_in, res_b_ff, res_b_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [ADW-1:0] lo_ff, lo_in, hi_ff, hi_in, md;

   // shared multiplier operands and accumulator
   logic signed [AW-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic signed [BPW-1:0] b1_ff, b1_in, b2_ff, b2_in;
   logic [CNTW-1:0] mul_cnt_ff, mul_cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic prod_v_ff, prod_v_in, prod_sh_ff, prod_sh_in, prod_neg_ff, prod_neg_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic acc_le0;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_user_ff, rsp_user_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic [KW-1:0] kidx;
   logic [BPW-1:0] b_sel;
   logic signed [AW-1:0] a_sel;
   logic [DIGIT_W-1:0] digit;
   logic signed [DIGIT_W:0] dig17;
   logic signed [AW-1:0] d_ord;

   assign rd_s = rd_ff[COEF_WIDTH-1:0];
   assign rd_b = rd_ff[2*COEF_WIDTH-1:COEF_WIDTH];
   assign accept = req_tvalid && req_tready;
   assign acc_le0 = acc_ff[ACCW-1] || (acc_ff == '0);
   assign md = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

   // write the stack, read one entry a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[size_ff[ADW-1:0]] <= {new_b_ff, new_s_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   // right end register
   always_ff @(posedge clock) begin
      if (reset) begin
         right_end_ff <= RIGHT_END_RESET;
      end else if (csr_wr_en) begin
         right_end_ff <= csr_wr_data;
      end
   end

   // select the read address
   always_comb begin
      unique case (state_ff)
         S_POP_CHK: rd_addr = ADW'(size_ff - SZW'(2));
         S_Q_LOOP:  rd_addr = (lo_ff == hi_ff) ? lo_ff : md;
         S_Q_RD1:   rd_addr = md + ADW'(1);
         default:   rd_addr = ADW'(size_ff - SZW'(1));
      endcase
   end

   // pick the multiplier digit, most significant first
   always_comb begin
      kidx = KW'(NCH - 1) - KW'(mul_cnt_ff[CNTW-1:1]);
      b_sel = mul_cnt_ff[0] ? b2_ff : b1_ff;
      a_sel = mul_cnt_ff[0] ? a2_ff : a1_ff;
      digit = b_sel[kidx*DIGIT_W +: DIGIT_W];
      dig17 = {(kidx == KW'(NCH - 1)) ? digit[DIGIT_W-1] : 1'b0, digit};
   end

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff <= '0;
         rsp_valid_ff <= 1'b0;
         prod_v_ff <= 1'b0;
         mul_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         prod_v_ff <= prod_v_in;
         mul_cnt_ff <= mul_cnt_in;
      end
      ret_ff <= ret_in;
      new_s_ff <= new_s_in;
      new_b_ff <= new_b_in;
      num_ff <= num_in;
      den_ff <= den_in;
      top_s_ff <= top_s_in;
      top_b_ff <= top_b_in;
      ent_s_ff <= ent_s_in;
      ent_b_ff <= ent_b_in;
      res_s_ff <= res_s_in;
      res_b_ff <= res_b_in;
      status_ff <= status_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      prod_ff <= prod_in;
      prod_sh_ff <= prod_sh_in;
      prod_neg_ff <= prod_neg_in;
      acc_ff <= acc_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      size_in = size_ff;
      new_s_in = new_s_ff;
      new_b_in = new_b_ff;
      num_in = num_ff;
      den_in = den_ff;
      top_s_in = top_s_ff;
      top_b_in = top_b_ff;
      ent_s_in = ent_s_ff;
      ent_b_in = ent_b_ff;
      res_s_in = res_s_ff;
      res_b_in = res_b_ff;
      status_in = status_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      mul_cnt_in = mul_cnt_ff;
      prod_in = a_sel * dig17;
      prod_v_in = 1'b0;
      prod_sh_in = ~mul_cnt_ff[0];
      prod_neg_in = mul_cnt_ff[0];
      acc_in = acc_ff;
      mem_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      d_ord = AW'(new_s_ff) - AW'(rd_s);

      // fold a registered product into the accumulator
      if (prod_v_ff) begin
         acc_in = (prod_sh_ff ? (acc_ff <<< DIGIT_W) : acc_ff)
                  + (prod_neg_ff ? -ACCW'(prod_ff) : ACCW'(prod_ff));
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_s_in = req_tdata[COEF_WIDTH-1:0];
               new_b_in = req_tdata[2*COEF_WIDTH-1:COEF_WIDTH];
               num_in = req_tdata[2*COEF_WIDTH+NUM_WIDTH-1:2*COEF_WIDTH];
               den_in = req_tdata[REQ_BITS-1:2*COEF_WIDTH+NUM_WIDTH];
               if (req_tdata[REQ_BITS-1:2*COEF_WIDTH+NUM_WIDTH] == '0) begin
                  den_in = DEN_WIDTH'(1);
               end
               res_s_in = '0;
               res_b_in = '0;
               if (req_tuser[0] == REQ_QUERY) begin
                  if (size_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in = S_OUT;
                  end else begin
                     lo_in = '0;
                     hi_in = ADW'(size_ff - SZW'(1));
                     state_in = S_Q_LOOP;
                  end
               end else begin
                  state_in = (size_ff == '0) ? S_PUSH : S_TOP;
               end
            end
         end
         // slope order check, then set up the dominance compare
         S_TOP: begin
            top_s_in = rd_s;
            top_b_in = rd_b;
            if (!d_ord[AW-1]) begin
               status_in = ST_ORDER;
               state_in = S_OUT;
            end else begin
               a1_in = AW'(rd_s) - AW'(new_s_ff);
               b1_in = BPW'(right_end_ff);
               a2_in = AW'(new_b_ff) - AW'(rd_b);
               b2_in = BPW'(1);
               ret_in = S_DOM;
               acc_in = '0;
               mul_cnt_in = '0;
               state_in = S_MUL;
            end
         end
         S_DOM: begin
            if (acc_le0) begin
               status_in = ST_DROP;
               state_in = S_OUT;
            end else begin
               state_in = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            state_in = (size_ff > SZW'(1)) ? S_POP_MUL : S_PUSH;
         end
         // set up the pop test against the line below the top
         S_POP_MUL: begin
            ent_s_in = rd_s;
            ent_b_in = rd_b;
            a1_in = AW'(rd_s) - AW'(top_s_ff);
            b1_in = BPW'(AW'(new_b_ff) - AW'(top_b_ff));
            a2_in = AW'(top_b_ff) - AW'(rd_b);
            b2_in = BPW'(AW'(top_s_ff) - AW'(new_s_ff));
            ret_in = S_POP_DEC;
            acc_in = '0;
            mul_cnt_in = '0;
            state_in = S_MUL;
         end
         S_POP_DEC: begin
            if (acc_le0) begin
               size_in = size_ff - SZW'(1);
               top_s_in = ent_s_ff;
               top_b_in = ent_b_ff;
               state_in = S_POP_CHK;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (size_ff >= SZW'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               mem_we = 1'b1;
               size_in = size_ff + SZW'(1);
               status_in = ST_OK;
            end
            state_in = S_OUT;
         end
         S_Q_LOOP: begin
            state_in = (lo_ff == hi_ff) ? S_Q_FIN : S_Q_RD1;
         end
         S_Q_RD1: begin
            ent_s_in = rd_s;
            ent_b_in = rd_b;
            state_in = S_Q_SETUP;
         end
         // compare the middle line with its successor at the point
         S_Q_SETUP: begin
            a1_in = AW'(ent_s_ff) - AW'(rd_s);
            b1_in = BPW'(num_ff);
            a2_in = AW'(rd_b) - AW'(ent_b_ff);
            b2_in = BPW'({1'b0, den_ff});
            ret_in = S_Q_STEP;
            acc_in = '0;
            mul_cnt_in = '0;
            state_in = S_MUL;
         end
         S_Q_STEP: begin
            if (acc_le0) begin
               hi_in = md;
            end else begin
               lo_in = md + ADW'(1);
            end
            state_in = S_Q_LOOP;
         end
         S_Q_FIN: begin
            res_s_in = rd_s;
            res_b_in = rd_b;
            status_in = ST_OK;
            state_in = S_OUT;
         end
         // run a1*b1 - a2*b2 digit by digit through the shared multiplier
         S_MUL: begin
            if (mul_cnt_ff < CNTW'(2 * NCH)) begin
               prod_v_in = 1'b1;
               mul_cnt_in = mul_cnt_ff + CNTW'(1);
            end else begin
               state_in = ret_ff;
            end
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = status_ff;
               rsp_data_in = RSP_DW'({size_ff, res_b_ff, res_s_ff});
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SZW'(DEPTH))
      else $error("line count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> size_ff < SZW'(DEPTH))
      else $error("push into full stack");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second transaction taken while busy");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_LOOP) |-> (lo_ff <= hi_ff && SZW'(hi_ff) < size_ff))
      else $error("search bounds out of range");

endmodule

`default_nettype wire
